### src/bounded_stack_sort_reverse_engine_unit_assert.svh
// assertion macros for the bounded stack engine
`ifndef BOUNDED_STACK_SORT_REVERSE_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_STACK_SORT_REVERSE_ENGINE_UNIT_ASSERT_SVH

// condition that must hold at every edge outside reset
`define BSSR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// implication checked in the same cycle
`define BSSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/bssr_pkg.sv
// shared constants, types and codes of the bounded stack engine
package bssr_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 5;
    localparam int REQ_W     = 3;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_LVL_W  = $clog2(CQ_DEPTH + 1);

    typedef logic [DATA_W-1:0] t_word;

    // request codes on the input port
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_POS    = 3'd0,
        REQ_DEL_POS    = 3'd1,
        REQ_INS_BOT    = 3'd2,
        REQ_REVERSE    = 3'd3,
        REQ_SORTED_INS = 3'd4,
        REQ_SORT       = 3'd5
    } t_req;

    // operation class after decode
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_DELETE,
        OP_REVERSE,
        OP_SORT
    } t_op;

    // where an insert places its value
    typedef enum logic [1:0] {
        INS_POS,
        INS_BOT,
        INS_SORTED
    } t_ins_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // back end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_REVERSE,
        BS_SORT,
        BS_DONE
    } t_bstate;

    // stack array update select
    typedef enum logic [2:0] {
        UPD_HOLD,
        UPD_INS,
        UPD_DEL,
        UPD_MIRROR,
        UPD_SHIFT,
        UPD_SORT
    } t_upd;

    typedef struct packed {
        t_op                op;
        t_ins_mode          mode;
        t_word              value;
        logic [POS_W-1:0]   position;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
        t_word              top;
        logic               top_valid;
    } t_result;

endpackage

### src/bssr_front.sv
// request decode and command queue in front of the stack engine
module bssr_front
    import bssr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic signed [IN_W-1:0] i_value,
    input  logic [POS_W-1:0]    i_position,
    output t_cmd                o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);

    t_cmd                   dec_cmd;
    t_cmd                   r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]    r_wr_ptr;
    logic [CQ_PTR_W-1:0]    r_rd_ptr;
    logic [CQ_LVL_W-1:0]    r_level;
    logic [CQ_LVL_W-1:0]    n_level;
    logic                   push_ok;
    logic                   pop_ok;

    // classify the request
    always_comb begin
        dec_cmd.value    = DATA_W'(i_value);
        dec_cmd.position = i_position;
        dec_cmd.mode     = INS_POS;
        unique case (i_req_type)
            REQ_INS_POS: begin
                dec_cmd.op   = OP_INSERT;
                dec_cmd.mode = INS_POS;
            end
            REQ_DEL_POS: dec_cmd.op = OP_DELETE;
            REQ_INS_BOT: begin
                dec_cmd.op   = OP_INSERT;
                dec_cmd.mode = INS_BOT;
            end
            REQ_REVERSE: dec_cmd.op = OP_REVERSE;
            REQ_SORTED_INS: begin
                dec_cmd.op   = OP_INSERT;
                dec_cmd.mode = INS_SORTED;
            end
            REQ_SORT:    dec_cmd.op = OP_SORT;
            default:     dec_cmd.op = OP_NOP;
        endcase
    end

    assign o_full      = (r_level == CQ_LVL_W'(CQ_DEPTH));
    assign o_cmd_valid = (r_level != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    // queue fill level
    always_comb begin
        n_level = r_level;
        if (push_ok && !pop_ok) begin
            n_level = r_level + CQ_LVL_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_level = r_level - CQ_LVL_W'(1);
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_level <= n_level;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + CQ_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + CQ_PTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

### src/bssr_back.sv
// stack register array and the sequencer that carries out commands
module bssr_back
    import bssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    output t_result     o_res,
    output logic        o_res_valid,
    input  logic        i_res_pop
);

    t_bstate            r_state;
    t_bstate            n_state;
    t_cmd               r_cmd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_steps;
    logic [CNT_W-1:0]   n_steps;
    t_status            r_status;
    t_status            n_status;
    t_word              r_entries [DEPTH];
    t_word              n_entries [DEPTH];
    t_result            r_res;
    logic               r_res_valid;

    t_upd               upd;
    logic [IDX_W-1:0]   upd_idx;
    logic               cmd_load;
    logic               res_load;
    logic               multi;
    logic               pos_bad;
    logic [CNT_W-1:0]   srt_idx;
    logic               ins_ok;
    logic [IDX_W-1:0]   ins_idx;
    t_word              top_word;

    assign multi   = (r_count > CNT_W'(1));
    assign pos_bad = (r_cmd.position == '0) ||
                     (CMP_W'(r_cmd.position) > CMP_W'(r_count));

    // sorted insert slot: just above the highest entry below the value
    always_comb begin
        srt_idx = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if ((CNT_W'(k) < r_count) &&
                ($signed(r_entries[k]) < $signed(r_cmd.value))) begin
                srt_idx = CNT_W'(k + 1);
            end
        end
    end

    // insert slot and range check
    always_comb begin
        ins_ok  = 1'b1;
        ins_idx = '0;
        unique case (r_cmd.mode)
            INS_POS: begin
                if (r_count != '0) begin
                    if (pos_bad) begin
                        ins_ok = 1'b0;
                    end else begin
                        ins_idx = IDX_W'(r_count - CNT_W'(r_cmd.position) + CNT_W'(1));
                    end
                end
            end
            INS_BOT:    ins_idx = '0;
            INS_SORTED: ins_idx = IDX_W'(srt_idx);
            default:    ins_ok  = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if ((r_cmd.op == OP_REVERSE) && multi) begin
                    n_state = BS_REVERSE;
                end else if ((r_cmd.op == OP_SORT) && multi) begin
                    n_state = BS_SORT;
                end else begin
                    n_state = BS_DONE;
                end
            end
            BS_REVERSE, BS_SORT: begin
                if (r_steps == '0) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (res_load) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        upd      = UPD_HOLD;
        upd_idx  = '0;
        n_count  = r_count;
        n_steps  = r_steps;
        n_status = r_status;
        cmd_load = 1'b0;
        res_load = 1'b0;
        unique case (r_state)
            BS_IDLE: cmd_load = i_cmd_valid;
            BS_EXEC: begin
                n_status = ST_DONE;
                case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (!ins_ok) begin
                            n_status = ST_RANGE;
                        end else begin
                            upd     = UPD_INS;
                            upd_idx = ins_idx;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_DELETE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (pos_bad) begin
                            n_status = ST_RANGE;
                        end else begin
                            upd     = UPD_DEL;
                            upd_idx = IDX_W'(r_count - CNT_W'(r_cmd.position));
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    OP_REVERSE: begin
                        // mirror the whole array, then slide the live part down
                        if (multi) begin
                            upd     = UPD_MIRROR;
                            n_steps = CNT_W'(DEPTH) - r_count;
                        end
                    end
                    OP_SORT: begin
                        // one odd-even pass per live entry
                        if (multi) begin
                            n_steps = r_count;
                        end
                    end
                    default: ;
                endcase
            end
            BS_REVERSE: begin
                if (r_steps != '0) begin
                    upd     = UPD_SHIFT;
                    n_steps = r_steps - CNT_W'(1);
                end
            end
            BS_SORT: begin
                if (r_steps != '0) begin
                    upd     = UPD_SORT;
                    n_steps = r_steps - CNT_W'(1);
                end
            end
            BS_DONE: res_load = !r_res_valid || i_res_pop;
            default: ;
        endcase
    end

    // stack array next value
    always_comb begin
        n_entries = r_entries;
        case (upd)
            UPD_INS: begin
                for (int i = 1; i < DEPTH; i++) begin
                    if (IDX_W'(i) > upd_idx) begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (IDX_W'(i) == upd_idx) begin
                        n_entries[i] = r_cmd.value;
                    end
                end
            end
            UPD_DEL: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (IDX_W'(i) >= upd_idx) begin
                        n_entries[i] = r_entries[i+1];
                    end
                end
            end
            UPD_MIRROR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    n_entries[i] = r_entries[DEPTH-1-i];
                end
            end
            UPD_SHIFT: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_entries[i] = r_entries[i+1];
                end
            end
            UPD_SORT: begin
                // compare and swap disjoint pairs of one parity
                for (int k = 0; k < DEPTH - 1; k++) begin
                    if (((k % 2) == int'(r_steps[0])) &&
                        (CNT_W'(k + 1) < r_count) &&
                        ($signed(r_entries[k+1]) < $signed(r_entries[k]))) begin
                        n_entries[k]   = r_entries[k+1];
                        n_entries[k+1] = r_entries[k];
                    end
                end
            end
            default: ;
        endcase
    end

    assign top_word = (r_count != '0) ? r_entries[IDX_W'(r_count - CNT_W'(1))] : '0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_status    <= ST_DONE;
            r_res_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_steps  <= n_steps;
            r_status <= n_status;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (cmd_load) begin
            r_cmd <= i_cmd;
        end
        if (res_load) begin
            r_res.status    <= r_status;
            r_res.count     <= r_count;
            r_res.top       <= top_word;
            r_res.top_valid <= (r_count != '0);
        end
    end

    assign o_cmd_pop   = cmd_load;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### src/bounded_stack_sort_reverse_engine_unit.sv
// Bounded stack of up to 16 signed words, requests in and one result per request out.
// Request channel: drive i_req_type, i_value, i_position with push; a transfer
// happens on a rising edge with push high and full low. A two-entry command
// queue sits behind this port, so up to two requests may wait while the stack
// works. Result channel: while empty is low the oldest result is on o_status,
// o_entry_count, o_top_value and o_top_valid; pop high on that edge takes it.
// Inserts, deletes and no-op codes are carried out in the execute state; a reverse
// of two or more entries mirrors the array and then slides the live part down,
// and a sort runs one odd-even pass per entry. The engine takes the next
// command only after the previous result has moved into the result register;
// the reverse slide counter and the sort pass counter set how long each runs.
// The result register holds one finished result: while the receiver stalls,
// the engine finishes the next command and then waits, and the command queue
// fills until full rises. Synchronous active-low reset empties the stack,
// the command queue and the result register; no clearing pass is needed.
module bounded_stack_sort_reverse_engine_unit
    import bssr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic signed [IN_W-1:0]  i_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic signed [OUT_W-1:0] o_top_value,
    output logic                    o_top_valid
);

    t_cmd       cmd;
    logic       cmd_valid;
    logic       cmd_pop;
    t_result    res;
    logic       res_valid;

    // request decode and command queue
    bssr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // stack array and sequencer
    bssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    // result port
    assign empty         = !res_valid;
    assign o_status      = res.status;
    assign o_entry_count = res.count;
    assign o_top_value   = OUT_W'(res.top);
    assign o_top_valid   = res.top_valid;

`include "bounded_stack_sort_reverse_engine_unit_assert.svh"

    // checks
    `BSSR_ASSERT_IMP(a_cmd_pop_valid, cmd_pop, cmd_valid, "command taken from an empty queue")
    `BSSR_ASSERT_IMP(a_count_bound, !empty, o_entry_count <= CNT_W'(DEPTH), "entry count above depth")
    `BSSR_ASSERT_IMP(a_top_valid, !empty, o_top_valid == (o_entry_count != '0), "top flag disagrees with count")
    `BSSR_ASSERT_IMP(a_full_status, !empty && (o_status == ST_FULL), o_entry_count == CNT_W'(DEPTH), "full status on a stack with room")

endmodule
